>>> sv/wlsg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the weighted least-squares gradient block.
// Depends on nothing; every other file imports it.
package wlsg_pkg;

   localparam int DATA_W = 32;
   localparam int ACC_W = 64;
   localparam int WIDE_W = 130;
   localparam int MIN_DIST_W = 17;
   localparam int MAX_VARS = 4;
   localparam int NUM_VARS_DEF = 4;
   localparam int FRAC_BITS_DEF = 16;
   localparam int ADDR_W = 3;

   localparam logic [MIN_DIST_W-1:0] MIN_DIST_RESET = 17'd1;
   localparam logic REG_MIN_DISTANCE = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SUM,
      ST_SQRT,
      ST_CHECK,
      ST_TERM,
      ST_ACC,
      ST_FINISH,
      ST_SOLVE
   } top_state_type;

   typedef enum logic [2:0] {
      SV_IDLE,
      SV_MULA,
      SV_MULB,
      SV_EVAL,
      SV_DIV,
      SV_STORE,
      SV_DONE
   } solve_state_type;

   typedef struct packed {
      logic done;
      logic singular;
   } solve_status_type;

   function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

>>> sv/wlsg_lane.sv
`timescale 1ns / 1ps
// One lane: a 32x32 product divided by the distance, one quotient bit per cycle.
// Depends on wlsg_pkg.
module wlsg_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [wlsg_pkg::DATA_W-1:0] a,
   input  logic [wlsg_pkg::DATA_W-1:0] b,
   input  logic                       neg,
   input  logic [wlsg_pkg::DATA_W-1:0] d,
   output logic                       done,
   output logic [wlsg_pkg::ACC_W-1:0] term
);
   import wlsg_pkg::*;

   localparam int CNT_W = $clog2(ACC_W + 1);

   logic [ACC_W-1:0]  dvd_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic [ACC_W-1:0]  prod;
   logic [DATA_W:0]   r2;
   logic              ge;
   logic [DATA_W:0]   rem_in;

   assign prod = a * b;
   assign r2 = {rem_ff, dvd_ff[ACC_W-1]};
   assign ge = r2 >= {1'b0, d};
   assign rem_in = ge ? (r2 - {1'b0, d}) : r2;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dvd_ff <= prod;
            rem_ff <= '0;
            cnt_ff <= CNT_W'(ACC_W);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            dvd_ff <= {dvd_ff[ACC_W-2:0], ge};
            rem_ff <= rem_in[DATA_W-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign term = neg ? (~dvd_ff + 1'b1) : dvd_ff;

endmodule

>>> sv/wlsg_solve.sv
`timescale 1ns / 1ps
// Merging stage: solves the 2x2 normal system per variable with a shared
// 64x64 multiplier in 32-bit partial products and a bit-serial divider. Depends on wlsg_pkg.
module wlsg_solve #(
   parameter int NUM_VARS = wlsg_pkg::NUM_VARS_DEF,
   parameter int FRAC_BITS = wlsg_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [wlsg_pkg::ACC_W-1:0]  sum_xx,
   input  logic signed [wlsg_pkg::ACC_W-1:0]  sum_xy,
   input  logic signed [wlsg_pkg::ACC_W-1:0]  sum_yy,
   input  logic signed [wlsg_pkg::ACC_W-1:0]  rhs_x [NUM_VARS],
   input  logic signed [wlsg_pkg::ACC_W-1:0]  rhs_y [NUM_VARS],
   output wlsg_pkg::solve_status_type         status,
   output logic [wlsg_pkg::DATA_W-1:0]        grad [2*NUM_VARS]
);
   import wlsg_pkg::*;

   localparam int NG = 2 * NUM_VARS;
   localparam int J_W = $clog2(NG);
   localparam int K_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
   localparam int NB = WIDE_W + FRAC_BITS;
   localparam int DCNT_W = $clog2(NB + 1);
   localparam int PW = 2 * ACC_W;

   solve_state_type state_ff, state_in;

   logic [1:0]               cnt_ff;
   logic [PW-1:0]            acc_ff;
   logic signed [WIDE_W-1:0] prod_a_ff;
   logic signed [WIDE_W-1:0] diff_ff;
   logic signed [WIDE_W-1:0] det_ff;
   logic                     det_phase_ff;
   logic [J_W-1:0]           j_ff;
   logic [NB-1:0]            dvd_ff;
   logic [WIDE_W-1:0]        rem_ff;
   logic [DATA_W:0]          q_ff;
   logic                     ovf_ff;
   logic [DCNT_W-1:0]        dcnt_ff;
   logic                     neg_ff;
   logic                     singular_ff;
   logic [DATA_W-1:0]        grad_ff [NG];

   logic [K_W-1:0]           k_idx;
   logic signed [ACC_W-1:0]  a_op, b_op;
   logic [ACC_W-1:0]         a_mag, b_mag;
   logic                     prod_neg;
   logic [DATA_W-1:0]        a_h, b_h;
   logic [ACC_W-1:0]         pp;
   logic [PW-1:0]            pp_shift;
   logic [PW-1:0]            acc_next;
   logic signed [WIDE_W-1:0] prod_w;
   logic [WIDE_W-1:0]        den_mag, num_mag;
   logic [WIDE_W-1:0]        r2, rem_in;
   logic                     ge;
   logic [DATA_W-1:0]        sat;
   logic                     mul_last;

   assign k_idx = (NUM_VARS > 1) ? K_W'(j_ff >> 1) : '0;

   always_comb begin
      if (det_phase_ff) begin
         a_op = (state_ff == SV_MULA) ? sum_xx : sum_xy;
         b_op = (state_ff == SV_MULA) ? sum_yy : sum_xy;
      end else if (!j_ff[0]) begin
         a_op = (state_ff == SV_MULA) ? sum_yy : sum_xy;
         b_op = (state_ff == SV_MULA) ? rhs_x[k_idx] : rhs_y[k_idx];
      end else begin
         a_op = (state_ff == SV_MULA) ? sum_xx : sum_xy;
         b_op = (state_ff == SV_MULA) ? rhs_y[k_idx] : rhs_x[k_idx];
      end
   end

   assign a_mag = a_op[ACC_W-1] ? (~a_op + 1'b1) : a_op;
   assign b_mag = b_op[ACC_W-1] ? (~b_op + 1'b1) : b_op;
   assign prod_neg = a_op[ACC_W-1] ^ b_op[ACC_W-1];
   assign a_h = cnt_ff[1] ? a_mag[ACC_W-1:DATA_W] : a_mag[DATA_W-1:0];
   assign b_h = cnt_ff[0] ? b_mag[ACC_W-1:DATA_W] : b_mag[DATA_W-1:0];
   assign pp = a_h * b_h;
   assign pp_shift = {{ACC_W{1'b0}}, pp} << (DATA_W * (32'(cnt_ff[1]) + 32'(cnt_ff[0])));
   assign acc_next = acc_ff + pp_shift;
   assign prod_w = prod_neg ? -$signed({2'b00, acc_next}) : $signed({2'b00, acc_next});
   assign mul_last = cnt_ff == 2'd3;

   assign den_mag = det_ff[WIDE_W-1] ? (~det_ff + 1'b1) : det_ff;
   assign num_mag = diff_ff[WIDE_W-1] ? (~diff_ff + 1'b1) : diff_ff;
   assign r2 = {rem_ff[WIDE_W-2:0], dvd_ff[NB-1]};
   assign ge = r2 >= den_mag;
   assign rem_in = ge ? (r2 - den_mag) : r2;

   always_comb begin
      if (neg_ff) begin
         if (ovf_ff || q_ff > {1'b0, 1'b1, {(DATA_W-1){1'b0}}}) begin
            sat = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            sat = ~q_ff[DATA_W-1:0] + 1'b1;
         end
      end else begin
         if (ovf_ff || q_ff[DATA_W] || q_ff[DATA_W-1]) begin
            sat = {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            sat = q_ff[DATA_W-1:0];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SV_IDLE: begin
            if (start) state_in = SV_MULA;
         end
         SV_MULA: begin
            if (mul_last) state_in = SV_MULB;
         end
         SV_MULB: begin
            if (mul_last) state_in = SV_EVAL;
         end
         SV_EVAL: begin
            if (det_phase_ff) begin
               state_in = (diff_ff == '0) ? SV_DONE : SV_MULA;
            end else begin
               state_in = SV_DIV;
            end
         end
         SV_DIV: begin
            if (dcnt_ff == DCNT_W'(1)) state_in = SV_STORE;
         end
         SV_STORE: begin
            state_in = (j_ff == J_W'(NG - 1)) ? SV_DONE : SV_MULA;
         end
         SV_DONE: begin
            state_in = SV_IDLE;
         end
         default: begin
            state_in = SV_IDLE;
         end
      endcase
   end

   always_comb begin
      status.done = state_ff == SV_DONE;
      status.singular = singular_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         SV_IDLE: begin
            if (start) begin
               singular_ff <= 1'b0;
               det_phase_ff <= 1'b1;
               j_ff <= '0;
               cnt_ff <= '0;
               acc_ff <= '0;
               for (int g = 0; g < NG; g++) grad_ff[g] <= '0;
            end
         end
         SV_MULA: begin
            cnt_ff <= cnt_ff + 1'b1;
            acc_ff <= mul_last ? '0 : acc_next;
            if (mul_last) prod_a_ff <= prod_w;
         end
         SV_MULB: begin
            cnt_ff <= cnt_ff + 1'b1;
            acc_ff <= mul_last ? '0 : acc_next;
            if (mul_last) diff_ff <= prod_a_ff - prod_w;
         end
         SV_EVAL: begin
            if (det_phase_ff) begin
               det_ff <= diff_ff;
               if (diff_ff == '0) begin
                  singular_ff <= 1'b1;
               end else begin
                  det_phase_ff <= 1'b0;
               end
            end else begin
               dvd_ff <= {num_mag, {FRAC_BITS{1'b0}}};
               rem_ff <= '0;
               q_ff <= '0;
               ovf_ff <= 1'b0;
               dcnt_ff <= DCNT_W'(NB);
               neg_ff <= diff_ff[WIDE_W-1] ^ det_ff[WIDE_W-1];
            end
         end
         SV_DIV: begin
            dvd_ff <= {dvd_ff[NB-2:0], 1'b0};
            rem_ff <= rem_in;
            q_ff <= {q_ff[DATA_W-1:0], ge};
            ovf_ff <= ovf_ff | q_ff[DATA_W];
            dcnt_ff <= dcnt_ff - 1'b1;
         end
         SV_STORE: begin
            grad_ff[j_ff] <= sat;
            j_ff <= j_ff + 1'b1;
         end
         SV_DONE: begin
            cnt_ff <= '0;
         end
         default: begin
            cnt_ff <= '0;
         end
      endcase
   end

   assign grad = grad_ff;

endmodule

>>> sv/weighted_least_squares_gradient.sv
`timescale 1ns / 1ps
// Top level: input capture, distance square root, parallel term lanes,
// accumulators and result register. Depends on wlsg_pkg, wlsg_lane and wlsg_solve.
//
// Channel   Ports                                  Handshake
// req       start, busy, req_*                     taken when start and not busy
// rsp       rsp_valid, rsp_*                       one-cycle strobe, no backpressure
// config    psel, penable, pwrite, paddr, pwdata,  APB write, pready tied high
//           prdata, pready
//
// A kept neighbor is squared and summed, takes the square root (one result bit per
// cycle) and runs the lane multiply and divide before the next accept. A dropped
// neighbor skips the lanes. The last neighbor of a node also runs the serial solver,
// which stops after the determinant when the matrix is singular.
// Reset clears the control state, the accumulators and min_distance (to 1).
// Results cannot be stalled; on a last neighbor busy stays high until the strobe.
module weighted_least_squares_gradient #(
   parameter int NUM_VARS = wlsg_pkg::NUM_VARS_DEF,
   parameter int FRAC_BITS = wlsg_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [wlsg_pkg::DATA_W-1:0] req_offset_x,
   input  logic signed [wlsg_pkg::DATA_W-1:0] req_offset_y,
   input  logic signed [wlsg_pkg::DATA_W-1:0] req_value_diff_0,
   input  logic signed [wlsg_pkg::DATA_W-1:0] req_value_diff_1,
   input  logic signed [wlsg_pkg::DATA_W-1:0] req_value_diff_2,
   input  logic signed [wlsg_pkg::DATA_W-1:0] req_value_diff_3,
   input  logic                               req_last_neighbor,
   output logic                               rsp_valid,
   output logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_x_0,
   output logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_y_0,
   output logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_x_1,
   output logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_y_1,
   output logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_x_2,
   output logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_y_2,
   output logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_x_3,
   output logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_y_3,
   output logic                               rsp_singular,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [wlsg_pkg::ADDR_W-1:0]        paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import wlsg_pkg::*;

   localparam int NL = 3 + 2 * NUM_VARS;
   localparam int NG = 2 * NUM_VARS;
   localparam int SQ_W = 2 * DATA_W;
   localparam int SQ_CNT_W = $clog2(DATA_W);

   top_state_type state_ff, state_in;

   logic [MIN_DIST_W-1:0]   min_dist_ff;
   logic [DATA_W-1:0]       ax_ff, ay_ff;
   logic                    nx_ff, ny_ff;
   logic [DATA_W-1:0]       av_ff [NUM_VARS];
   logic                    nv_ff [NUM_VARS];
   logic                    last_ff;
   logic [SQ_W-1:0]         sqa_ff, sqb_ff;
   logic [SQ_W-1:0]         sq_rem_ff, sq_res_ff, sq_bit_ff;
   logic [SQ_CNT_W-1:0]     sq_cnt_ff;
   logic signed [ACC_W-1:0] sum_xx_ff, sum_xy_ff, sum_yy_ff;
   logic signed [ACC_W-1:0] rhs_x_ff [NUM_VARS];
   logic signed [ACC_W-1:0] rhs_y_ff [NUM_VARS];
   logic [DATA_W-1:0]       grad_rsp_ff [2*MAX_VARS];
   logic                    singular_rsp_ff;
   logic                    rsp_valid_ff;

   logic [DATA_W-1:0]       req_vd [MAX_VARS];
   logic [SQ_W-1:0]         sq_t, sq_rem_in, sq_res_in;
   logic                    sq_ge;
   logic [DATA_W-1:0]       root_d;
   logic                    keep;
   logic                    lane_start;
   logic                    solve_start;
   logic [DATA_W-1:0]       lane_a [NL];
   logic [DATA_W-1:0]       lane_b [NL];
   logic                    lane_neg [NL];
   logic [NL-1:0]           lane_done;
   logic [ACC_W-1:0]        lane_term [NL];
   solve_status_type        solve_status;
   logic [DATA_W-1:0]       solve_grad [NG];
   logic [DATA_W-1:0]       grad_sel [2*MAX_VARS];
   logic                    cfg_write;

   assign req_vd[0] = req_value_diff_0;
   assign req_vd[1] = req_value_diff_1;
   assign req_vd[2] = req_value_diff_2;
   assign req_vd[3] = req_value_diff_3;

   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_MIN_DISTANCE);
   assign prdata = (paddr[ADDR_W-1] == REG_MIN_DISTANCE) ? 32'(min_dist_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= MIN_DIST_RESET;
      end else if (cfg_write) begin
         min_dist_ff <= pwdata[MIN_DIST_W-1:0];
      end
   end

   assign sq_t = sq_res_ff + sq_bit_ff;
   assign sq_ge = sq_rem_ff >= sq_t;
   assign sq_rem_in = sq_ge ? (sq_rem_ff - sq_t) : sq_rem_ff;
   assign sq_res_in = sq_ge ? ((sq_res_ff >> 1) + sq_bit_ff) : (sq_res_ff >> 1);
   assign root_d = sq_res_ff[DATA_W-1:0];
   assign keep = (root_d != '0) && (root_d >= DATA_W'(min_dist_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sq_cnt_ff == SQ_CNT_W'(DATA_W - 1)) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = keep ? ST_TERM : ST_FINISH;
         end
         ST_TERM: begin
            if (&lane_done) state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = last_ff ? ST_SOLVE : ST_IDLE;
         end
         ST_SOLVE: begin
            if (solve_status.done) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy = state_ff != ST_IDLE;
      lane_start = (state_ff == ST_CHECK) && keep;
      solve_start = (state_ff == ST_FINISH) && last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_ff == ST_SOLVE) && solve_status.done;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         ax_ff <= mag32(req_offset_x);
         ay_ff <= mag32(req_offset_y);
         nx_ff <= req_offset_x[DATA_W-1];
         ny_ff <= req_offset_y[DATA_W-1];
         last_ff <= req_last_neighbor;
         for (int k = 0; k < NUM_VARS; k++) begin
            av_ff[k] <= mag32(req_vd[k]);
            nv_ff[k] <= req_vd[k][DATA_W-1];
         end
      end
      if (state_ff == ST_LOAD) begin
         sqa_ff <= ax_ff * ax_ff;
         sqb_ff <= ay_ff * ay_ff;
      end
      if (state_ff == ST_SUM) begin
         sq_rem_ff <= sqa_ff + sqb_ff;
         sq_res_ff <= '0;
         sq_bit_ff <= {2'b01, {(SQ_W-2){1'b0}}};
         sq_cnt_ff <= '0;
      end
      if (state_ff == ST_SQRT) begin
         sq_rem_ff <= sq_rem_in;
         sq_res_ff <= sq_res_in;
         sq_bit_ff <= sq_bit_ff >> 2;
         sq_cnt_ff <= sq_cnt_ff + 1'b1;
      end
      if (state_ff == ST_SOLVE && solve_status.done) begin
         grad_rsp_ff <= grad_sel;
         singular_rsp_ff <= solve_status.singular;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (state_ff == ST_SOLVE && solve_status.done)) begin
         sum_xx_ff <= '0;
         sum_xy_ff <= '0;
         sum_yy_ff <= '0;
         for (int k = 0; k < NUM_VARS; k++) begin
            rhs_x_ff[k] <= '0;
            rhs_y_ff[k] <= '0;
         end
      end else if (state_ff == ST_ACC) begin
         sum_xx_ff <= sum_xx_ff + $signed(lane_term[0]);
         sum_xy_ff <= sum_xy_ff + $signed(lane_term[1]);
         sum_yy_ff <= sum_yy_ff + $signed(lane_term[2]);
         for (int k = 0; k < NUM_VARS; k++) begin
            rhs_x_ff[k] <= rhs_x_ff[k] + $signed(lane_term[3 + 2*k]);
            rhs_y_ff[k] <= rhs_y_ff[k] + $signed(lane_term[4 + 2*k]);
         end
      end
   end

   assign lane_a[0] = ax_ff;
   assign lane_b[0] = ax_ff;
   assign lane_neg[0] = 1'b0;
   assign lane_a[1] = ax_ff;
   assign lane_b[1] = ay_ff;
   assign lane_neg[1] = nx_ff ^ ny_ff;
   assign lane_a[2] = ay_ff;
   assign lane_b[2] = ay_ff;
   assign lane_neg[2] = 1'b0;

   for (genvar k = 0; k < NUM_VARS; k++) begin : g_var
      assign lane_a[3 + 2*k] = av_ff[k];
      assign lane_b[3 + 2*k] = ax_ff;
      assign lane_neg[3 + 2*k] = nv_ff[k] ^ nx_ff;
      assign lane_a[4 + 2*k] = av_ff[k];
      assign lane_b[4 + 2*k] = ay_ff;
      assign lane_neg[4 + 2*k] = nv_ff[k] ^ ny_ff;
   end

   for (genvar l = 0; l < NL; l++) begin : g_lane
      wlsg_lane u_lane (
         .clock (clock),
         .reset (reset),
         .start (lane_start),
         .a     (lane_a[l]),
         .b     (lane_b[l]),
         .neg   (lane_neg[l]),
         .d     (root_d),
         .done  (lane_done[l]),
         .term  (lane_term[l])
      );
   end

   wlsg_solve #(
      .NUM_VARS  (NUM_VARS),
      .FRAC_BITS (FRAC_BITS)
   ) u_solve (
      .clock  (clock),
      .reset  (reset),
      .start  (solve_start),
      .sum_xx (sum_xx_ff),
      .sum_xy (sum_xy_ff),
      .sum_yy (sum_yy_ff),
      .rhs_x  (rhs_x_ff),
      .rhs_y  (rhs_y_ff),
      .status (solve_status),
      .grad   (solve_grad)
   );

   for (genvar g = 0; g < 2*MAX_VARS; g++) begin : g_sel
      if (g < NG) begin : g_used
         assign grad_sel[g] = solve_grad[g];
      end else begin : g_unused
         assign grad_sel[g] = '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_grad_x_0 = grad_rsp_ff[0];
   assign rsp_grad_y_0 = grad_rsp_ff[1];
   assign rsp_grad_x_1 = grad_rsp_ff[2];
   assign rsp_grad_y_1 = grad_rsp_ff[3];
   assign rsp_grad_x_2 = grad_rsp_ff[4];
   assign rsp_grad_y_2 = grad_rsp_ff[5];
   assign rsp_grad_x_3 = grad_rsp_ff[6];
   assign rsp_grad_y_3 = grad_rsp_ff[7];
   assign rsp_singular = singular_rsp_ff;

endmodule

>>> sv/wlsg_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the weighted least-squares gradient block, and the bind
// that attaches them. Depends on wlsg_pkg and the top level.
module wlsg_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_x_0,
   input logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_y_0,
   input logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_x_1,
   input logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_y_1,
   input logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_x_2,
   input logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_y_2,
   input logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_x_3,
   input logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_y_3,
   input logic                               rsp_singular
);
   import wlsg_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_idle_at_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |->
         (rsp_grad_x_0 == '0 && rsp_grad_y_0 == '0 && rsp_grad_x_1 == '0 &&
          rsp_grad_y_1 == '0 && rsp_grad_x_2 == '0 && rsp_grad_y_2 == '0 &&
          rsp_grad_x_3 == '0 && rsp_grad_y_3 == '0))
      else $error("singular result carries nonzero gradients");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind weighted_least_squares_gradient wlsg_checker u_wlsg_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_grad_x_0 (rsp_grad_x_0),
   .rsp_grad_y_0 (rsp_grad_y_0),
   .rsp_grad_x_1 (rsp_grad_x_1),
   .rsp_grad_y_1 (rsp_grad_y_1),
   .rsp_grad_x_2 (rsp_grad_x_2),
   .rsp_grad_y_2 (rsp_grad_y_2),
   .rsp_grad_x_3 (rsp_grad_x_3),
   .rsp_grad_y_3 (rsp_grad_y_3),
   .rsp_singular (rsp_singular)
);

>>> test/weighted_least_squares_gradient_checker.sv
`timescale 1ns / 1ps
// Checker for the weighted least-squares gradient block: snoops the request, result
// and APB ports, predicts every gradient word and compares it. Depends on wlsg_pkg.
module weighted_least_squares_gradient_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic signed [wlsg_pkg::DATA_W-1:0] req_offset_x,
   input  logic signed [wlsg_pkg::DATA_W-1:0] req_offset_y,
   input  logic signed [wlsg_pkg::DATA_W-1:0] req_value_diff_0,
   input  logic signed [wlsg_pkg::DATA_W-1:0] req_value_diff_1,
   input  logic signed [wlsg_pkg::DATA_W-1:0] req_value_diff_2,
   input  logic signed [wlsg_pkg::DATA_W-1:0] req_value_diff_3,
   input  logic                               req_last_neighbor,
   input  logic                               rsp_valid,
   input  logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_x_0,
   input  logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_y_0,
   input  logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_x_1,
   input  logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_y_1,
   input  logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_x_2,
   input  logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_y_2,
   input  logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_x_3,
   input  logic signed [wlsg_pkg::DATA_W-1:0] rsp_grad_y_3,
   input  logic                               rsp_singular,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [wlsg_pkg::ADDR_W-1:0]        paddr,
   input  logic [31:0]                        pwdata,
   input  logic                               pready,
   output int                                 failures,
   output int                                 pending
);
   import wlsg_pkg::*;

   typedef struct packed {
      logic singular;
      logic [7:0][DATA_W-1:0] grad;
   } gradient_word_type;

   gradient_word_type gradient_queue[$];
   logic [MIN_DIST_W-1:0] min_dist;
   logic [ACC_W-1:0] acc_xx, acc_xy, acc_yy;
   logic [ACC_W-1:0] acc_bx[MAX_VARS];
   logic [ACC_W-1:0] acc_by[MAX_VARS];

   assign pending = gradient_queue.size();

   function automatic logic [63:0] root_floor(input logic [63:0] s);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > s) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (s >= res + bit_v) begin
            s = s - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] magnitude(input logic [31:0] v);
      return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
   endfunction

   function automatic logic [63:0] add_term(input logic [63:0] acc, input logic neg,
                                            input logic [63:0] prod, input logic [63:0] d);
      logic [63:0] q;
      q = prod / d;
      return neg ? acc - q : acc + q;
   endfunction

   function automatic logic [31:0] solve_ratio(input logic signed [129:0] num,
                                               input logic signed [129:0] det);
      logic signed [199:0] n, dn, q;
      n = num;
      dn = det;
      n = n <<< FRAC_BITS_DEF;
      q = n / dn;
      if (q > 200'sd2147483647) return 32'h7FFF_FFFF;
      if (q < -200'sd2147483648) return 32'h8000_0000;
      return q[31:0];
   endfunction

   task automatic predict_neighbor(input logic [7:0][31:0] f, input logic last);
      logic [63:0] ax, ay, av, d;
      logic nx, ny, nv;
      logic signed [129:0] s00, s01, s11, bx, by, det;
      gradient_word_type w;
      ax = magnitude(f[0]);
      ay = magnitude(f[1]);
      nx = f[0][31];
      ny = f[1][31];
      d = root_floor(ax * ax + ay * ay);
      if (d != 0 && d >= {47'd0, min_dist}) begin
         acc_xx = add_term(acc_xx, 1'b0, ax * ax, d);
         acc_xy = add_term(acc_xy, nx ^ ny, ax * ay, d);
         acc_yy = add_term(acc_yy, 1'b0, ay * ay, d);
         for (int k = 0; k < NUM_VARS_DEF; k++) begin
            av = magnitude(f[2 + k]);
            nv = f[2 + k][31];
            acc_bx[k] = add_term(acc_bx[k], nv ^ nx, av * ax, d);
            acc_by[k] = add_term(acc_by[k], nv ^ ny, av * ay, d);
         end
      end
      if (last) begin
         w = '0;
         s00 = signed'(acc_xx);
         s01 = signed'(acc_xy);
         s11 = signed'(acc_yy);
         det = s00 * s11 - s01 * s01;
         if (det == 0) begin
            w.singular = 1'b1;
         end else begin
            for (int k = 0; k < NUM_VARS_DEF; k++) begin
               bx = signed'(acc_bx[k]);
               by = signed'(acc_by[k]);
               w.grad[2 * k] = solve_ratio(s11 * bx - s01 * by, det);
               w.grad[2 * k + 1] = solve_ratio(s00 * by - s01 * bx, det);
            end
         end
         gradient_queue.push_back(w);
         acc_xx = 0;
         acc_xy = 0;
         acc_yy = 0;
         for (int k = 0; k < MAX_VARS; k++) begin
            acc_bx[k] = 0;
            acc_by[k] = 0;
         end
      end
   endtask

   task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
      failures++;
      if (failures <= 10)
         $display("mismatch %s: expected %h, got %h at %0t", what, exp_v, act_v, $realtime);
   endtask

   initial begin
      failures = 0;
      min_dist = MIN_DIST_RESET;
      acc_xx = 0;
      acc_xy = 0;
      acc_yy = 0;
      for (int k = 0; k < MAX_VARS; k++) begin
         acc_bx[k] = 0;
         acc_by[k] = 0;
      end
   end

   always @(posedge clock) begin
      logic [7:0][31:0] f;
      gradient_word_type exp_w;
      logic [7:0][31:0] act;
      if (!reset) begin
         if (psel && penable && pwrite && pready && (paddr >> 2) == REG_MIN_DISTANCE)
            min_dist = pwdata[MIN_DIST_W-1:0];
         if (start && !busy) begin
            f = {32'd0, 32'd0, req_value_diff_3, req_value_diff_2, req_value_diff_1,
                 req_value_diff_0, req_offset_y, req_offset_x};
            predict_neighbor(f, req_last_neighbor);
         end
         if (rsp_valid) begin
            act = {rsp_grad_y_3, rsp_grad_x_3, rsp_grad_y_2, rsp_grad_x_2,
                   rsp_grad_y_1, rsp_grad_x_1, rsp_grad_y_0, rsp_grad_x_0};
            if (gradient_queue.size() == 0) begin
               report("unexpected gradient word", 32'd0, act[0]);
            end else begin
               exp_w = gradient_queue.pop_front();
               for (int i = 0; i < 8; i++)
                  if (act[i] !== exp_w.grad[i])
                     report($sformatf("grad_%s_%0d", (i % 2) ? "y" : "x", i / 2),
                            exp_w.grad[i], act[i]);
               if (rsp_singular !== exp_w.singular)
                  report("singular", {31'd0, exp_w.singular}, {31'd0, rsp_singular});
            end
         end
      end
   end

endmodule

>>> test/weighted_least_squares_gradient_test.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, neighbor streams and APB writes for the gradient block.
// Depends on wlsg_pkg, weighted_least_squares_gradient and its checker.
module weighted_least_squares_gradient_test;
   import wlsg_pkg::*;

   logic clock, reset, start, busy;
   logic signed [DATA_W-1:0] offset_x, offset_y, vd0, vd1, vd2, vd3;
   logic last_neighbor;
   logic rsp_valid, rsp_singular;
   logic signed [DATA_W-1:0] gx0, gy0, gx1, gy1, gx2, gy2, gx3, gy3;
   logic psel, penable, pwrite, pready;
   logic [ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;
   int failures, pending, words_sent, cycles;

   weighted_least_squares_gradient i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_offset_x(offset_x), .req_offset_y(offset_y),
      .req_value_diff_0(vd0), .req_value_diff_1(vd1),
      .req_value_diff_2(vd2), .req_value_diff_3(vd3),
      .req_last_neighbor(last_neighbor),
      .rsp_valid(rsp_valid),
      .rsp_grad_x_0(gx0), .rsp_grad_y_0(gy0), .rsp_grad_x_1(gx1), .rsp_grad_y_1(gy1),
      .rsp_grad_x_2(gx2), .rsp_grad_y_2(gy2), .rsp_grad_x_3(gx3), .rsp_grad_y_3(gy3),
      .rsp_singular(rsp_singular),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   weighted_least_squares_gradient_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_offset_x(offset_x), .req_offset_y(offset_y),
      .req_value_diff_0(vd0), .req_value_diff_1(vd1),
      .req_value_diff_2(vd2), .req_value_diff_3(vd3),
      .req_last_neighbor(last_neighbor),
      .rsp_valid(rsp_valid),
      .rsp_grad_x_0(gx0), .rsp_grad_y_0(gy0), .rsp_grad_x_1(gx1), .rsp_grad_y_1(gy1),
      .rsp_grad_x_2(gx2), .rsp_grad_y_2(gy2), .rsp_grad_x_3(gx3), .rsp_grad_y_3(gy3),
      .rsp_singular(rsp_singular),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .failures(failures), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 8000000) begin
            $display("weighted_least_squares_gradient_test: errors");
            $finish;
         end
      end
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         3: return $urandom_range(0, 65536 * 4) - 65536 * 2;
         default: return $urandom_range(0, 1 << 22) - (1 << 21);
      endcase
   endfunction

   task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic send_word(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] v0, input logic [31:0] v1,
                            input logic [31:0] v2, input logic [31:0] v3,
                            input logic last, input int idle_pct);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         repeat ($urandom_range(1, 150)) @(negedge clock);
      end
      start = 1'b1;
      offset_x = x;
      offset_y = y;
      vd0 = v0;
      vd1 = v1;
      vd2 = v2;
      vd3 = v3;
      last_neighbor = last;
      do @(posedge clock); while (busy);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_node(input int n, input int idle_pct);
      for (int i = 0; i < n; i++)
         send_word(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                   $urandom, pick_coord(), i == n - 1, idle_pct);
   endtask

   task automatic drain();
      start = 1'b0;
      while (pending != 0) @(posedge clock);
      do @(posedge clock); while (busy);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int idle_pct[5];
      logic [31:0] dist_val[5];
      idle_pct[0] = 0;
      idle_pct[1] = 53;
      idle_pct[2] = 0;
      idle_pct[3] = 53;
      idle_pct[4] = 34;
      start = 1'b0;
      offset_x = 0;
      offset_y = 0;
      vd0 = 0;
      vd1 = 0;
      vd2 = 0;
      vd3 = 0;
      last_neighbor = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = 0;
      pwdata = 0;
      words_sent = 0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed nodes at the reset threshold.
      send_word(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 5, 6, 1'b1, 0);
      send_word(32'h0001_0000, 0, 32'h0002_0000, 0, 0, 0, 1'b1, 0);
      send_word(32'h0001_0000, 0, 32'h0001_0000, 32'h8000_0000, 1, 2, 1'b0, 0);
      send_word(0, 32'h0001_0000, 32'h0003_0000, 32'h7FFF_FFFF, 3, 4, 1'b0, 0);
      send_word(0, 0, 32'h1234_5678, 0, 0, 0, 1'b1, 0);
      send_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0);
      send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'hFFFF_FFFF, 1, 1'b1, 0);
      send_word(32'h0002_0000, 32'h0002_0000, 1, 1, 1, 1, 1'b0, 0);
      send_word(32'hFFFE_0000, 32'hFFFE_0000, 2, 2, 2, 2, 1'b1, 0);
      send_word(1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0);
      send_word(0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 0);
      send_word(32'h0000_8000, 32'h0000_4000, 7, 8, 9, 10, 1'b0, 0);
      send_word(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
                0, 32'h0010_0000, 1'b1, 0);
      drain();

      dist_val[0] = 0;
      dist_val[1] = 65536;
      dist_val[2] = 1;
      dist_val[3] = $urandom_range(0, 65536);
      dist_val[4] = $urandom_range(0, 4096);
      apb_write(4, $urandom);
      for (int ph = 0; ph < 5; ph++) begin
         apb_write(REG_MIN_DISTANCE, dist_val[ph]);
         while (words_sent < 20 + 190 * (ph + 1))
            send_node($urandom_range(0, 3) == 0 ? 1 : $urandom_range(2, 8), idle_pct[ph]);
         drain();
      end

      repeat (50) @(posedge clock);
      if (failures == 0) begin
         $display("weighted_least_squares_gradient_test: clean");
      end else begin
         $display("weighted_least_squares_gradient_test: errors");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/wlsg_pkg.sv
sv/wlsg_lane.sv
sv/wlsg_solve.sv
sv/weighted_least_squares_gradient.sv
sv/wlsg_checker.sv
test/weighted_least_squares_gradient_checker.sv
test/weighted_least_squares_gradient_test.sv
